@@ hw/rtl/frdr_pkg.sv @@
// Shared types and constants of the Fresnel dielectric reflectance core.
// No dependencies.
package frdr_pkg;

  localparam int RAD_W      = 60;
  localparam int ROOT_W     = 30;
  localparam int REM_W      = 32;
  localparam int DEN_W      = 48;
  localparam int DREM_W     = 49;
  localparam int QUO_W      = 17;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int LATENCY    = 54;

  localparam logic [1:0]  CASE_NORMAL  = 2'd0;
  localparam logic [1:0]  CASE_TIR     = 2'd1;
  localparam logic [1:0]  CASE_MIRROR  = 2'd2;

  localparam logic        CFG_INCIDENT = 1'b0;
  localparam logic        CFG_TRANSMIT = 1'b1;

  localparam logic [15:0] INCIDENT_RESET = 16'd4096;
  localparam logic [15:0] TRANSMIT_RESET = 16'd6144;
  localparam logic [15:0] ONE_Q15        = 16'd32768;

  typedef struct packed {
    logic        mir;
    logic        tir;
    logic [15:0] m;
    logic [31:0] n2;
    logic [14:0] c;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_lane_t;

  typedef struct packed {
    logic mir;
    logic tir;
    logic dz_p;
    logic dz_s;
  } flag_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [DEN_W-1:0]  den;
    logic [QUO_W-1:0]  quo;
  } div_lane_t;

endpackage

@@ hw/rtl/frdr_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
// Depends on frdr_pkg.
module frdr_sqrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_in,
  input  frdr_pkg::side_t     side_in,
  input  frdr_pkg::sqrt_lane_t lane_in,
  output logic                vld_r,
  output frdr_pkg::side_t     side_r,
  output frdr_pkg::sqrt_lane_t lane_r
);
  import frdr_pkg::*;

  logic [REM_W+1:0] tmp;
  logic [REM_W+1:0] trial;
  logic             ge;
  sqrt_lane_t       lane_nxt;

  always_comb begin
    tmp   = {lane_in.rem, lane_in.rad[RAD_W-1 -: 2]};
    trial = (REM_W+2)'({lane_in.root, 2'b01});
    ge    = (tmp >= trial);
    lane_nxt.rem  = ge ? REM_W'(tmp - trial) : REM_W'(tmp);
    lane_nxt.root = {lane_in.root[ROOT_W-2:0], ge};
    lane_nxt.rad  = {lane_in.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    side_r <= side_in;
    lane_r <= lane_nxt;
  end

endmodule

@@ hw/rtl/frdr_div_cell.sv @@
// One quotient bit of both ratio dividers, restoring form.
// Depends on frdr_pkg.
module frdr_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_in,
  input  frdr_pkg::flag_t     flag_in,
  input  frdr_pkg::div_lane_t par_in,
  input  frdr_pkg::div_lane_t perp_in,
  output logic                vld_r,
  output frdr_pkg::flag_t     flag_r,
  output frdr_pkg::div_lane_t par_r,
  output frdr_pkg::div_lane_t perp_r
);
  import frdr_pkg::*;

  function automatic div_lane_t div_step(input div_lane_t l);
    div_lane_t        o;
    logic             ge;
    logic [DREM_W-1:0] r;
    ge    = (l.rem >= DREM_W'(l.den));
    r     = ge ? (l.rem - DREM_W'(l.den)) : l.rem;
    o.rem = {r[DREM_W-2:0], 1'b0};
    o.den = l.den;
    o.quo = {l.quo[QUO_W-2:0], ge};
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    flag_r <= flag_in;
    par_r  <= div_step(par_in);
    perp_r <= div_step(perp_in);
  end

endmodule

@@ hw/rtl/fresnel_dielectric_reflectance_core.sv @@
// Fresnel dielectric reflectance core: a fully pipelined chain of cells.
// Stages in order: 0-2, sqrt cells, products, numerators, dividers, squares, output.
// Throughput: one item per cycle; busy stays low, results cannot be stalled.
// Depth is set by the 30 square root cells and the 17 divider cells.
// Synchronous active-low reset clears all valid bits and loads the index registers.
// Depends on frdr_pkg, frdr_sqrt_cell and frdr_div_cell.
module fresnel_dielectric_reflectance_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] in_cos_angle,
  output logic        out_valid,
  output logic [15:0] out_reflectance,
  output logic [1:0]  out_case_code,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import frdr_pkg::*;

  logic [15:0] idx_inc_r, idx_trn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_inc_r <= INCIDENT_RESET;
      idx_trn_r <= TRANSMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INCIDENT: idx_inc_r <= cfg_data;
        CFG_TRANSMIT: idx_trn_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: clamp and swap
  logic signed [15:0] cos_cl;
  logic               neg;
  logic [14:0]        c_abs;
  logic               s0_vld_r, s0_mir_r;
  logic [15:0]        s0_m_r, s0_n_r;
  logic [14:0]        s0_c_r;

  always_comb begin
    if (in_cos_angle > 16'sd16384) begin
      cos_cl = 16'sd16384;
    end else if (in_cos_angle < -16'sd16384) begin
      cos_cl = -16'sd16384;
    end else begin
      cos_cl = in_cos_angle;
    end
    neg   = cos_cl[15];
    c_abs = neg ? 15'(-cos_cl) : cos_cl[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
    s0_mir_r <= (idx_trn_r == 16'd0);
    s0_m_r   <= neg ? idx_trn_r : idx_inc_r;
    s0_n_r   <= neg ? idx_inc_r : idx_trn_r;
    s0_c_r   <= c_abs;
  end

  // stage 1: squares
  logic [29:0] c2;
  logic        s1_vld_r, s1_mir_r;
  logic [15:0] s1_m_r;
  logic [14:0] s1_c_r;
  logic [31:0] s1_n2_r, s1_m2_r;
  logic [28:0] s1_s2_r;

  assign c2 = s0_c_r * s0_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
    s1_mir_r <= s0_mir_r;
    s1_m_r   <= s0_m_r;
    s1_c_r   <= s0_c_r;
    s1_n2_r  <= s0_n_r * s0_n_r;
    s1_m2_r  <= s0_m_r * s0_m_r;
    s1_s2_r  <= 29'(30'h1000_0000 - c2);
  end

  // stage 2: total internal reflection test and radicand
  logic [60:0] lhs, rhs;
  logic        s2_vld_r;
  side_t       s2_side_r;
  sqrt_lane_t  s2_lane_r;

  assign lhs = 61'(s1_m2_r) * 61'(s1_s2_r);
  assign rhs = {1'b0, s1_n2_r, 28'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_side_r.mir  <= s1_mir_r;
    s2_side_r.tir  <= (lhs >= rhs);
    s2_side_r.m    <= s1_m_r;
    s2_side_r.n2   <= s1_n2_r;
    s2_side_r.c    <= s1_c_r;
    s2_lane_r.rem  <= '0;
    s2_lane_r.root <= '0;
    s2_lane_r.rad  <= RAD_W'(rhs - lhs);
  end

  // square root chain
  logic       sq_vld [0:SQRT_STEPS];
  side_t      sq_side[0:SQRT_STEPS];
  sqrt_lane_t sq_lane[0:SQRT_STEPS];

  assign sq_vld[0]  = s2_vld_r;
  assign sq_side[0] = s2_side_r;
  assign sq_lane[0] = s2_lane_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    frdr_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (sq_vld[i]),
      .side_in (sq_side[i]),
      .lane_in (sq_lane[i]),
      .vld_r   (sq_vld[i+1]),
      .side_r  (sq_side[i+1]),
      .lane_r  (sq_lane[i+1])
    );
  end

  // products
  side_t       sq_out;
  logic [ROOT_W-1:0] q;
  logic        mul_vld_r, mul_mir_r, mul_tir_r;
  logic [46:0] mul_ap_r;
  logic [45:0] mul_bp_r;
  logic [30:0] mul_as_r;
  logic [29:0] mul_bs_r;

  assign sq_out = sq_side[SQRT_STEPS];
  assign q      = sq_lane[SQRT_STEPS].root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= sq_vld[SQRT_STEPS];
    end
    mul_mir_r <= sq_out.mir;
    mul_tir_r <= sq_out.tir;
    mul_ap_r  <= sq_out.n2 * sq_out.c;
    mul_bp_r  <= sq_out.m * q;
    mul_as_r  <= sq_out.m * sq_out.c;
    mul_bs_r  <= q;
  end

  // numerators and denominators
  logic [DEN_W-1:0] ap, bp, as_e, bs;
  logic             nd_vld_r;
  flag_t            nd_flag_r;
  div_lane_t        nd_par_r, nd_perp_r;

  assign ap   = DEN_W'(mul_ap_r);
  assign bp   = DEN_W'(mul_bp_r);
  assign as_e = DEN_W'(mul_as_r);
  assign bs   = DEN_W'(mul_bs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_vld_r <= 1'b0;
    end else begin
      nd_vld_r <= mul_vld_r;
    end
    nd_flag_r.mir  <= mul_mir_r;
    nd_flag_r.tir  <= mul_tir_r;
    nd_flag_r.dz_p <= ((ap + bp) == '0);
    nd_flag_r.dz_s <= ((as_e + bs) == '0);
    nd_par_r.rem   <= DREM_W'((ap >= bp) ? (ap - bp) : (bp - ap));
    nd_par_r.den   <= ap + bp;
    nd_par_r.quo   <= '0;
    nd_perp_r.rem  <= DREM_W'((as_e >= bs) ? (as_e - bs) : (bs - as_e));
    nd_perp_r.den  <= as_e + bs;
    nd_perp_r.quo  <= '0;
  end

  // divider chain
  logic      dv_vld [0:DIV_STEPS];
  flag_t     dv_flag[0:DIV_STEPS];
  div_lane_t dv_par [0:DIV_STEPS];
  div_lane_t dv_perp[0:DIV_STEPS];

  assign dv_vld[0]  = nd_vld_r;
  assign dv_flag[0] = nd_flag_r;
  assign dv_par[0]  = nd_par_r;
  assign dv_perp[0] = nd_perp_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    frdr_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (dv_vld[i]),
      .flag_in (dv_flag[i]),
      .par_in  (dv_par[i]),
      .perp_in (dv_perp[i]),
      .vld_r   (dv_vld[i+1]),
      .flag_r  (dv_flag[i+1]),
      .par_r   (dv_par[i+1]),
      .perp_r  (dv_perp[i+1])
    );
  end

  // squares of the ratios
  flag_t            dv_out;
  logic [QUO_W-1:0] rp, rs;
  logic             sqr_vld_r;
  flag_t            sqr_flag_r;
  logic [33:0]      sqr_p_r, sqr_s_r;

  assign dv_out = dv_flag[DIV_STEPS];
  assign rp = dv_out.dz_p ? QUO_W'(17'h10000) : dv_par[DIV_STEPS].quo;
  assign rs = dv_out.dz_s ? QUO_W'(17'h10000) : dv_perp[DIV_STEPS].quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqr_vld_r <= 1'b0;
    end else begin
      sqr_vld_r <= dv_vld[DIV_STEPS];
    end
    sqr_flag_r <= dv_out;
    sqr_p_r    <= rp * rp;
    sqr_s_r    <= rs * rs;
  end

  // round, saturate, select case
  logic [35:0] sum_rnd;
  logic [17:0] refl;

  assign sum_rnd = 36'(sqr_p_r) + 36'(sqr_s_r) + 36'h2_0000;
  assign refl    = sum_rnd[35:18];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sqr_vld_r;
    end
    if (sqr_flag_r.mir) begin
      out_reflectance <= ONE_Q15;
      out_case_code   <= CASE_MIRROR;
    end else if (sqr_flag_r.tir) begin
      out_reflectance <= ONE_Q15;
      out_case_code   <= CASE_TIR;
    end else begin
      out_reflectance <= (refl > 18'(ONE_Q15)) ? ONE_Q15 : refl[15:0];
      out_case_code   <= CASE_NORMAL;
    end
  end

  a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reflectance <= ONE_Q15)
    else $error("reflectance above one");

  a_special_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_case_code != CASE_NORMAL |-> out_reflectance == ONE_Q15)
    else $error("special case without full reflectance");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_case_code <= CASE_MIRROR)
    else $error("undefined case code");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a transfer in");

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for fresnel_dielectric_reflectance_core: directed and random cosines
// under several index settings, checked against an in-bench reflectance predictor.
// Depends on frdr_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import frdr_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_cos_angle = '0;
  logic               out_valid;
  logic [15:0]        out_reflectance;
  logic [1:0]         out_case_code;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_INCIDENT;
  logic [15:0]        cfg_data = '0;

  typedef struct {
    logic [15:0] refl;
    logic [1:0]  code;
  } refl_result_t;

  refl_result_t expected_refl_q[$];
  logic [15:0]  idx_inc = INCIDENT_RESET;
  logic [15:0]  idx_trn = TRANSMIT_RESET;
  int           errors = 0;
  int           sent = 0;
  int           got = 0;
  int           idle_pct = 0;
  int           quiet_cycles = 0;

  fresnel_dielectric_reflectance_core DUT (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] amp_ratio(logic [63:0] a, logic [63:0] b);
    logic [63:0] den;
    logic [63:0] num;
    den = a + b;
    num = (a >= b) ? a - b : b - a;
    if (den == 0) return 64'd1 << 16;
    return (num << 16) / den;
  endfunction

  function automatic refl_result_t predict_reflectance(logic signed [15:0] cosv_in);
    refl_result_t res;
    int           cosv;
    logic [63:0]  m, n, t, c, s2, lhs, rhs, q, rp, rs, sum, refl;
    cosv = int'(cosv_in);
    m = 64'(idx_inc);
    n = 64'(idx_trn);
    if (n == 0) begin
      res.refl = ONE_Q15;
      res.code = CASE_MIRROR;
      return res;
    end
    if (cosv > 16384) cosv = 16384;
    if (cosv < -16384) cosv = -16384;
    if (cosv < 0) begin
      t = m;
      m = n;
      n = t;
      cosv = -cosv;
    end
    c = 64'(cosv);
    s2 = (64'd1 << 28) - c * c;
    lhs = m * m * s2;
    rhs = (n * n) << 28;
    if (lhs >= rhs) begin
      res.refl = ONE_Q15;
      res.code = CASE_TIR;
      return res;
    end
    q = int_sqrt(rhs - lhs);
    rp = amp_ratio(n * n * c, m * q);
    rs = amp_ratio(m * c, q);
    sum = rp * rp + rs * rs;
    refl = (sum + (64'd1 << 17)) >> 18;
    if (refl > 32768) refl = 32768;
    res.refl = refl[15:0];
    res.code = CASE_NORMAL;
    return res;
  endfunction

  always @(posedge clk) begin
    refl_result_t e;
    if (rst_n && start && !busy) begin
      expected_refl_q.push_back(predict_reflectance(in_cos_angle));
      sent++;
    end
    if (rst_n && out_valid) begin
      got++;
      if (expected_refl_q.size() == 0) begin
        $display("%0t: unexpected result refl=%0d code=%0d", $time, out_reflectance,
                 out_case_code);
        errors++;
      end else begin
        e = expected_refl_q.pop_front();
        if (out_reflectance !== e.refl) begin
          $display("%0t: reflectance expected %0d actual %0d", $time, e.refl,
                   out_reflectance);
          errors++;
        end
        if (out_case_code !== e.code) begin
          $display("%0t: case_code expected %0d actual %0d", $time, e.code, out_case_code);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("FAIL fresnel_dielectric_reflectance_core");
      $finish;
    end
  end

  task automatic send_cos(logic signed [15:0] v);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cos_angle <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_refl_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_indices(logic [15:0] inc, logic [15:0] trn);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INCIDENT;
    cfg_data <= inc;
    @(posedge clk);
    cfg_index <= CFG_TRANSMIT;
    cfg_data <= trn;
    @(posedge clk);
    cfg_we <= 1'b0;
    idx_inc = inc;
    idx_trn = trn;
  endtask

  function automatic logic signed [15:0] rand_cos();
    case ($urandom_range(3, 0))
      0: return 16'($urandom);
      1: return 16'($urandom_range(32767, 0) - 16384);
      2: return 16'($urandom_range(16384, 14000));
      default: return 16'(-$urandom_range(16384, 14000));
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] pts[$] = '{16'sh7FFF, -16'sh8000, 16'sd16384, -16'sd16384,
      16'sd16385, -16'sd16385, 16'sd0, 16'sd1, -16'sd1, 16'sd8192, -16'sd8192,
      16'sd11585, -16'sd11585, 16'sh5555, 16'shAAAA};
    foreach (pts[i]) send_cos(pts[i]);
    drain();
    write_indices(16'd6144, 16'd4096);
    foreach (pts[i]) send_cos(pts[i]);
    drain();
    write_indices(16'd4096, 16'd0);
    send_cos(16'sd8192);
    send_cos(-16'sd8192);
    drain();
    write_indices(16'd0, 16'd4096);
    send_cos(16'sd0);
    send_cos(-16'sd0);
    send_cos(16'sd100);
    send_cos(-16'sd100);
    drain();
    write_indices(16'hFFFF, 16'hFFFF);
    send_cos(16'sd0);
    send_cos(16'sd16384);
    send_cos(-16'sd5000);
    drain();
  endtask

  task automatic test_random(int pct, int count);
    idle_pct = pct;
    repeat (count) begin
      if ($urandom_range(49, 0) == 0) begin
        drain();
        case ($urandom_range(3, 0))
          0: write_indices(16'($urandom), 16'($urandom));
          1: write_indices(16'($urandom_range(8192, 2048)), 16'($urandom_range(8192, 2048)));
          2: write_indices(16'($urandom_range(16384, 0)), 16'd0);
          default: write_indices(16'hFFFF, 16'($urandom_range(3, 0)));
        endcase
      end
      send_cos(rand_cos());
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_indices(INCIDENT_RESET, TRANSMIT_RESET);
    test_random(0, 500);
    test_random(59, 450);
    test_random(0, 450);
    test_random(36, 450);
    $display("Covered %0d transfers, %0d results, index extremes, mirror and TIR cases.",
             sent, got);
    if (errors == 0) $display("PASS fresnel_dielectric_reflectance_core");
    else $display("FAIL fresnel_dielectric_reflectance_core");
    $finish;
  end
endmodule
